FILE: rtl/mer_pkg.sv
// Shared types, constants and microprogram of the midpoint ellipse rasterizer.
`timescale 1ns / 1ps
package mer_pkg;

  localparam int UA_BITS = 5;
  typedef logic [UA_BITS-1:0] uaddr_t;

  localparam uaddr_t UA_FETCH      = 5'd0;
  localparam uaddr_t UA_START      = 5'd1;
  localparam uaddr_t UA_STEP       = 5'd6;
  localparam uaddr_t UA_R2         = 5'd15;
  localparam uaddr_t UA_R2_FIN     = 5'd19;
  localparam uaddr_t UA_R1         = 5'd20;
  localparam uaddr_t UA_R1_FIN     = 5'd24;
  localparam uaddr_t UA_EMIT_SPAN  = 5'd25;
  localparam uaddr_t UA_EMIT_POINT = 5'd27;
  localparam uaddr_t UA_MARK       = 5'd31;

  localparam logic [1:0] KIND_POINT = 2'd0;
  localparam logic [1:0] KIND_SPAN  = 2'd1;
  localparam logic [1:0] KIND_MARK  = 2'd2;

  localparam logic       CFG_FILL_MODE   = 1'b0;
  localparam logic       CFG_BORDER_SIZE = 1'b1;
  localparam logic [3:0] BORDER_RESET    = 4'd1;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_FETCH,
    OP_MUL_XX,
    OP_MUL_YY,
    OP_MUL_RX2Y,
    OP_INIT_PY,
    OP_INIT_D,
    OP_SW_TT,
    OP_SW_UU,
    OP_SW_RYTT,
    OP_SW_RXUU,
    OP_SW_ADD,
    OP_SW_SUB,
    OP_R2_PY,
    OP_R2_TMP,
    OP_R2_PX,
    OP_R2_TMPX,
    OP_R2_FIN,
    OP_R1_PX,
    OP_R1_TMP,
    OP_R1_PY,
    OP_R1_TMPY,
    OP_R1_FIN,
    OP_EMIT_S0,
    OP_EMIT_S1,
    OP_EMIT_P0,
    OP_EMIT_P1,
    OP_EMIT_P2,
    OP_EMIT_P3,
    OP_EMIT_MARK
  } uop_e;

  typedef enum logic [3:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_DISPATCH,
    COND_EMIT,
    COND_NOT_BUSY,
    COND_REGION2,
    COND_PX_LT_PY,
    COND_D_NEG,
    COND_D_GT0
  } cond_e;

  typedef struct packed {
    uop_e   op;
    cond_e  cond;
    uaddr_t target;
  } ctrl_t;

  typedef struct packed {
    logic accept;
    logic action;
    logic busy;
    logic region2;
    logic px_lt_py;
    logic d_neg;
    logic d_gt0;
    logic fill;
    logic hold;
  } status_t;

  function automatic ctrl_t ucode_word(input uaddr_t addr);
    ctrl_t w;
    w = '{OP_NOP, COND_NEXT, UA_FETCH};
    case (addr)
      5'd0:    w = '{OP_FETCH,     COND_DISPATCH, UA_FETCH};
      5'd1:    w = '{OP_MUL_XX,    COND_NEXT,     UA_FETCH};
      5'd2:    w = '{OP_MUL_YY,    COND_NEXT,     UA_FETCH};
      5'd3:    w = '{OP_MUL_RX2Y,  COND_NEXT,     UA_FETCH};
      5'd4:    w = '{OP_INIT_PY,   COND_NEXT,     UA_FETCH};
      5'd5:    w = '{OP_INIT_D,    COND_EMIT,     UA_FETCH};
      5'd6:    w = '{OP_NOP,       COND_NOT_BUSY, UA_MARK};
      5'd7:    w = '{OP_NOP,       COND_REGION2,  UA_R2};
      5'd8:    w = '{OP_NOP,       COND_PX_LT_PY, UA_R1};
      5'd9:    w = '{OP_SW_TT,     COND_NEXT,     UA_FETCH};
      5'd10:   w = '{OP_SW_UU,     COND_NEXT,     UA_FETCH};
      5'd11:   w = '{OP_SW_RYTT,   COND_NEXT,     UA_FETCH};
      5'd12:   w = '{OP_SW_RXUU,   COND_NEXT,     UA_FETCH};
      5'd13:   w = '{OP_SW_ADD,    COND_NEXT,     UA_FETCH};
      5'd14:   w = '{OP_SW_SUB,    COND_NEXT,     UA_FETCH};
      5'd15:   w = '{OP_R2_PY,     COND_NEXT,     UA_FETCH};
      5'd16:   w = '{OP_R2_TMP,    COND_D_GT0,    UA_R2_FIN};
      5'd17:   w = '{OP_R2_PX,     COND_NEXT,     UA_FETCH};
      5'd18:   w = '{OP_R2_TMPX,   COND_NEXT,     UA_FETCH};
      5'd19:   w = '{OP_R2_FIN,    COND_EMIT,     UA_FETCH};
      5'd20:   w = '{OP_R1_PX,     COND_NEXT,     UA_FETCH};
      5'd21:   w = '{OP_R1_TMP,    COND_D_NEG,    UA_R1_FIN};
      5'd22:   w = '{OP_R1_PY,     COND_NEXT,     UA_FETCH};
      5'd23:   w = '{OP_R1_TMPY,   COND_NEXT,     UA_FETCH};
      5'd24:   w = '{OP_R1_FIN,    COND_EMIT,     UA_FETCH};
      5'd25:   w = '{OP_EMIT_S0,   COND_NEXT,     UA_FETCH};
      5'd26:   w = '{OP_EMIT_S1,   COND_NEXT,     UA_FETCH};
      5'd27:   w = '{OP_EMIT_P0,   COND_NEXT,     UA_FETCH};
      5'd28:   w = '{OP_EMIT_P1,   COND_NEXT,     UA_FETCH};
      5'd29:   w = '{OP_EMIT_P2,   COND_NEXT,     UA_FETCH};
      5'd30:   w = '{OP_EMIT_P3,   COND_ALWAYS,   UA_FETCH};
      5'd31:   w = '{OP_EMIT_MARK, COND_ALWAYS,   UA_FETCH};
      default: w = '{OP_NOP,       COND_ALWAYS,   UA_FETCH};
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/mer_seq.sv
// Microcode sequencer: step counter, control store and branch logic.
`timescale 1ns / 1ps
module mer_seq import mer_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  uaddr_t pc_q, pc_d;
  uaddr_t pc_inc;
  logic   taken;

  assign ctrl_o = ucode_word(pc_q);
  assign pc_inc = pc_q + uaddr_t'(1);

  always_comb begin
    case (ctrl_o.cond)
      COND_ALWAYS:   taken = 1'b1;
      COND_NOT_BUSY: taken = !status_i.busy;
      COND_REGION2:  taken = status_i.region2;
      COND_PX_LT_PY: taken = status_i.px_lt_py;
      COND_D_NEG:    taken = status_i.d_neg;
      COND_D_GT0:    taken = status_i.d_gt0;
      default:       taken = 1'b0;
    endcase
  end

  always_comb begin
    pc_d = pc_inc;
    if (status_i.hold) begin
      pc_d = pc_q;
    end else begin
      case (ctrl_o.cond)
        COND_DISPATCH: begin
          if (!status_i.accept) begin
            pc_d = pc_q;
          end else begin
            pc_d = status_i.action ? UA_STEP : UA_START;
          end
        end
        COND_EMIT: begin
          pc_d = status_i.fill ? UA_EMIT_SPAN : UA_EMIT_POINT;
        end
        default: begin
          pc_d = taken ? ctrl_o.target : pc_inc;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= UA_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

FILE: rtl/midpoint_ellipse_rasterizer_unit.sv
// Top level of the midpoint ellipse rasterizer: config port, datapath, output register.
`timescale 1ns / 1ps
// The block takes one item at a time and runs a 32-word microprogram, one datapath
// operation per cycle unless a beat is held back by a stalled output, with a single
// COORD_BITS*2+2 square multiplier whose product is registered. Fill mode adds two
// beats per item. A step while idle gives one marker beat. A beat waiting in the
// output register does not block the next item.
module midpoint_ellipse_rasterizer_unit import mer_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         action_i,
  input  logic [COORD_BITS-1:0]        centre_x_i,
  input  logic [COORD_BITS-1:0]        centre_y_i,
  input  logic [COORD_BITS-1:0]        corner_x_i,
  input  logic [COORD_BITS-1:0]        corner_y_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   kind_o,
  output logic signed [COORD_BITS+1:0] pos_x_o,
  output logic signed [COORD_BITS+1:0] pos_y_o,
  output logic signed [COORD_BITS+1:0] span_end_x_o,
  output logic                         last_o,
  output logic                         done_res_o
);

  localparam int C  = COORD_BITS;
  localparam int OW = COORD_BITS + 2;
  localparam int SQ = 2 * COORD_BITS;
  localparam int MW = 2 * COORD_BITS + 2;
  localparam int SL = 3 * COORD_BITS + 4;
  localparam int DW = 4 * COORD_BITS + 4;

  ctrl_t   ctrl;
  status_t status;

  logic fill_q, fill_d;
  logic [3:0] border_q, border_d;
  logic cfg_wr;

  logic [C-1:0]         cx_q, cx_d, cy_q, cy_d, x_q, x_d, y_q, y_d;
  logic [SQ-1:0]        rx2_q, rx2_d, ry2_q, ry2_d;
  logic signed [SL-1:0] px_q, px_d, py_q, py_d;
  logic signed [DW-1:0] d_q, d_d, tmp_q, tmp_d;
  logic [DW-1:0]        prod_q, prod_d;
  logic                 region2_q, region2_d, busy_q, busy_d;

  logic                 out_valid_q, out_valid_d;
  logic [1:0]           kind_q, kind_d;
  logic signed [OW-1:0] posx_q, posx_d, posy_q, posy_d, endx_q, endx_d;
  logic                 last_q, last_d, done_q, done_d;

  logic [MW-1:0] mul_a, mul_b;
  logic [DW-1:0] mul_p;
  logic [C-1:0]  dx, dy, y_dec;
  logic [C:0]    t_odd;
  logic          accept, emit_op, out_free, hold, y_zero;
  logic [OW-1:0] cxw, cyw, xw, yw, sw, two;
  logic [OW-1:0] span_x0, span_x1;

  mer_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == CFG_BORDER_SIZE) ? {28'd0, border_q} : {31'd0, fill_q};

  always_comb begin
    fill_d   = fill_q;
    border_d = border_q;
    if (cfg_wr) begin
      if (paddr[2] == CFG_FILL_MODE) begin
        fill_d = pwdata[0];
      end else begin
        border_d = pwdata[3:0];
      end
    end
  end

  assign accept     = in_valid_i && (ctrl.op == OP_FETCH);
  assign in_stall_o = (ctrl.op != OP_FETCH);
  assign emit_op    = ctrl.op inside {OP_EMIT_S0, OP_EMIT_S1, OP_EMIT_P0, OP_EMIT_P1,
                                      OP_EMIT_P2, OP_EMIT_P3, OP_EMIT_MARK};
  assign out_free   = !out_valid_q || !out_stall_i;
  assign hold       = emit_op && !out_free;

  assign status.accept   = accept;
  assign status.action   = action_i;
  assign status.busy     = busy_q;
  assign status.region2  = region2_q;
  assign status.px_lt_py = (px_q < py_q);
  assign status.d_neg    = d_q[DW-1];
  assign status.d_gt0    = !d_q[DW-1] && (d_q != '0);
  assign status.fill     = fill_q;
  assign status.hold     = hold;

  assign dx    = (corner_x_i >= centre_x_i) ? corner_x_i - centre_x_i : centre_x_i - corner_x_i;
  assign dy    = (corner_y_i >= centre_y_i) ? corner_y_i - centre_y_i : centre_y_i - corner_y_i;
  assign y_dec = y_q - C'(1);
  assign t_odd = {x_q, 1'b1};

  always_comb begin
    case (ctrl.op)
      OP_MUL_XX:   begin mul_a = MW'(x_q);   mul_b = MW'(x_q);        end
      OP_MUL_YY:   begin mul_a = MW'(y_q);   mul_b = MW'(y_q);        end
      OP_MUL_RX2Y: begin mul_a = MW'(rx2_q); mul_b = MW'(y_q);        end
      OP_SW_TT:    begin mul_a = MW'(t_odd); mul_b = MW'(t_odd);      end
      OP_SW_UU:    begin mul_a = MW'(y_dec); mul_b = MW'(y_dec);      end
      OP_SW_RYTT:  begin mul_a = MW'(ry2_q); mul_b = d_q[MW-1:0];     end
      OP_SW_RXUU:  begin mul_a = MW'(rx2_q); mul_b = tmp_q[MW-1:0];   end
      OP_SW_ADD:   begin mul_a = MW'(rx2_q); mul_b = MW'(ry2_q);      end
      default:     begin mul_a = '0;         mul_b = '0;              end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign y_zero  = (y_q == '0);
  assign cxw     = OW'(cx_q);
  assign cyw     = OW'(cy_q);
  assign xw      = OW'(x_q);
  assign yw      = OW'(y_q);
  assign sw      = OW'(border_q);
  assign two     = OW'(2);
  assign span_x0 = cxw - xw + sw - two;
  assign span_x1 = cxw + xw - sw + two;

  always_comb begin
    cx_d = cx_q; cy_d = cy_q; x_d = x_q; y_d = y_q;
    rx2_d = rx2_q; ry2_d = ry2_q; px_d = px_q; py_d = py_q;
    d_d = d_q; tmp_d = tmp_q; prod_d = prod_q;
    region2_d = region2_q; busy_d = busy_q;
    kind_d = kind_q; posx_d = posx_q; posy_d = posy_q; endx_d = endx_q;
    last_d = last_q; done_d = done_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (!hold) begin
      case (ctrl.op)
        OP_FETCH: begin
          if (accept && !action_i) begin
            cx_d = centre_x_i;
            cy_d = centre_y_i;
            x_d  = dx;
            y_d  = dy;
          end
        end
        OP_MUL_XX:   prod_d = mul_p;
        OP_MUL_YY: begin
          rx2_d  = prod_q[SQ-1:0];
          prod_d = mul_p;
        end
        OP_MUL_RX2Y: begin
          ry2_d  = prod_q[SQ-1:0];
          prod_d = mul_p;
        end
        OP_INIT_PY: begin
          py_d = SL'(prod_q << 1);
          px_d = '0;
          d_d  = DW'({ry2_q, 2'b00}) + DW'(rx2_q);
        end
        OP_INIT_D: begin
          d_d       = d_q - (prod_q << 2);
          x_d       = '0;
          region2_d = 1'b0;
          busy_d    = 1'b1;
        end
        OP_SW_TT:    prod_d = mul_p;
        OP_SW_UU: begin
          d_d    = prod_q;
          prod_d = mul_p;
        end
        OP_SW_RYTT: begin
          tmp_d  = prod_q;
          prod_d = mul_p;
        end
        OP_SW_RXUU: begin
          d_d    = prod_q;
          prod_d = mul_p;
        end
        OP_SW_ADD: begin
          d_d    = d_q + (prod_q << 2);
          prod_d = mul_p;
        end
        OP_SW_SUB: begin
          d_d       = d_q - (prod_q << 2);
          region2_d = 1'b1;
        end
        OP_R2_PY:   py_d  = py_q - SL'({rx2_q, 1'b0});
        OP_R2_TMP:  tmp_d = DW'(rx2_q) - DW'(py_q);
        OP_R2_PX:   px_d  = px_q + SL'({ry2_q, 1'b0});
        OP_R2_TMPX: begin
          tmp_d = tmp_q + DW'(px_q);
          x_d   = x_q + C'(1);
        end
        OP_R2_FIN: begin
          d_d = d_q + (tmp_q <<< 2);
          y_d = y_dec;
        end
        OP_R1_PX:   px_d  = px_q + SL'({ry2_q, 1'b0});
        OP_R1_TMP:  tmp_d = DW'(ry2_q) + DW'(px_q);
        OP_R1_PY: begin
          py_d = py_q - SL'({rx2_q, 1'b0});
          y_d  = y_dec;
        end
        OP_R1_TMPY: tmp_d = tmp_q - DW'(py_q);
        OP_R1_FIN: begin
          d_d = d_q + (tmp_q <<< 2);
          x_d = x_q + C'(1);
        end
        OP_EMIT_S0, OP_EMIT_S1: begin
          out_valid_d = 1'b1;
          kind_d      = KIND_SPAN;
          posx_d      = span_x0;
          posy_d      = (ctrl.op == OP_EMIT_S0) ? cyw + yw - sw : cyw - yw + sw;
          endx_d      = span_x1;
          last_d      = 1'b0;
          done_d      = y_zero;
        end
        OP_EMIT_P0, OP_EMIT_P1, OP_EMIT_P2, OP_EMIT_P3: begin
          out_valid_d = 1'b1;
          kind_d      = KIND_POINT;
          posx_d      = (ctrl.op == OP_EMIT_P0 || ctrl.op == OP_EMIT_P2) ? cxw + xw : cxw - xw;
          posy_d      = (ctrl.op == OP_EMIT_P0 || ctrl.op == OP_EMIT_P1) ? cyw + yw : cyw - yw;
          endx_d      = '0;
          last_d      = (ctrl.op == OP_EMIT_P3);
          done_d      = y_zero;
          if (ctrl.op == OP_EMIT_P3 && y_zero) begin
            busy_d = 1'b0;
          end
        end
        OP_EMIT_MARK: begin
          out_valid_d = 1'b1;
          kind_d      = KIND_MARK;
          posx_d      = '0;
          posy_d      = '0;
          endx_d      = '0;
          last_d      = 1'b1;
          done_d      = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= 1'b0;
      border_q    <= BORDER_RESET;
      region2_q   <= 1'b0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      border_q    <= border_d;
      region2_q   <= region2_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q   <= cx_d;
    cy_q   <= cy_d;
    x_q    <= x_d;
    y_q    <= y_d;
    rx2_q  <= rx2_d;
    ry2_q  <= ry2_d;
    px_q   <= px_d;
    py_q   <= py_d;
    d_q    <= d_d;
    tmp_q  <= tmp_d;
    prod_q <= prod_d;
    kind_q <= kind_d;
    posx_q <= posx_d;
    posy_q <= posy_d;
    endx_q <= endx_d;
    last_q <= last_d;
    done_q <= done_d;
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign pos_x_o      = posx_q;
  assign pos_y_o      = posy_q;
  assign span_end_x_o = endx_q;
  assign last_o       = last_q;
  assign done_res_o   = done_q;

endmodule

FILE: rtl/mer_checker.sv
// Port-level checks of the midpoint ellipse rasterizer and their binding.
`timescale 1ns / 1ps
module mer_checker import mer_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [1:0]                   kind_o,
  input logic signed [COORD_BITS+1:0] pos_x_o,
  input logic signed [COORD_BITS+1:0] pos_y_o,
  input logic signed [COORD_BITS+1:0] span_end_x_o,
  input logic                         last_o,
  input logic                         done_res_o
);

  a_mark_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_MARK |->
      last_o && done_res_o && pos_x_o == '0 && pos_y_o == '0 && span_end_x_o == '0)
    else $error("idle marker beat malformed");

  a_point_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_POINT |-> span_end_x_o == '0)
    else $error("point beat carries a span end");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken in two consecutive cycles");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(kind_o) && $stable(pos_x_o) && $stable(pos_y_o)
      && $stable(last_o))
    else $error("stalled output beat changed");

endmodule

bind midpoint_ellipse_rasterizer_unit mer_checker #(.COORD_BITS(COORD_BITS)) u_mer_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .kind_o       (kind_o),
  .pos_x_o      (pos_x_o),
  .pos_y_o      (pos_y_o),
  .span_end_x_o (span_end_x_o),
  .last_o       (last_o),
  .done_res_o   (done_res_o)
);

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the midpoint ellipse rasterizer unit.
`timescale 1ns / 1ps
module tb_top;
  import mer_pkg::*;

  localparam int CB = 12;
  localparam int OW = CB + 2;
  localparam int COORD_MAX = (1 << CB) - 1;
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP = 1'b1;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int TAIL_CYCLES = 60;
  localparam int IDLE_LIMIT = 4000;
  localparam int PHASE_ITEMS = 24;
  localparam int NUM_ROWS = 23;

  typedef struct packed {
    logic [1:0]           kind;
    logic signed [OW-1:0] pos_x;
    logic signed [OW-1:0] pos_y;
    logic signed [OW-1:0] span_end;
    logic                 last;
    logic                 done;
  } beat_t;

  typedef struct packed {
    logic          action;
    logic [CB-1:0] cx;
    logic [CB-1:0] cy;
    logic [CB-1:0] qx;
    logic [CB-1:0] qy;
    logic          typed;
  } row_t;

  localparam beat_t MARK_BEAT = '{KIND_MARK, '0, '0, '0, 1'b1, 1'b1};

  // typed rows are idle steps whose single marker beat is known up front
  localparam row_t DIRECTED [NUM_ROWS] = '{
    '{ACT_STEP,  12'd0,    12'd0,    12'd0,    12'd0,    1'b1},
    '{ACT_START, 12'd0,    12'd0,    12'd0,    12'd0,    1'b0},
    '{ACT_STEP,  12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1},
    '{ACT_START, 12'd4095, 12'd4095, 12'd0,    12'd0,    1'b0},
    '{ACT_STEP,  12'd0,    12'd0,    12'd0,    12'd0,    1'b0},
    '{ACT_STEP,  12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0},
    '{ACT_START, 12'd0,    12'd0,    12'd4095, 12'd4095, 1'b0},
    '{ACT_STEP,  12'd0,    12'd0,    12'd0,    12'd0,    1'b0},
    '{ACT_START, 12'd100,  12'd200,  12'd100,  12'd203,  1'b0},
    '{ACT_STEP,  12'd0,    12'd0,    12'd0,    12'd0,    1'b0},
    '{ACT_STEP,  12'd0,    12'd0,    12'd0,    12'd0,    1'b0},
    '{ACT_STEP,  12'd0,    12'd0,    12'd0,    12'd0,    1'b0},
    '{ACT_STEP,  12'd0,    12'd0,    12'd0,    12'd0,    1'b1},
    '{ACT_START, 12'd2048, 12'd2048, 12'd2051, 12'd2046, 1'b0},
    '{ACT_STEP,  12'd0,    12'd0,    12'd0,    12'd0,    1'b0},
    '{ACT_STEP,  12'd0,    12'd0,    12'd0,    12'd0,    1'b0},
    '{ACT_STEP,  12'd0,    12'd0,    12'd0,    12'd0,    1'b0},
    '{ACT_STEP,  12'd0,    12'd0,    12'd0,    12'd0,    1'b0},
    '{ACT_STEP,  12'd0,    12'd0,    12'd0,    12'd0,    1'b0},
    '{ACT_STEP,  12'd0,    12'd0,    12'd0,    12'd0,    1'b0},
    '{ACT_START, 12'd1365, 12'd2730, 12'd1360, 12'd2735, 1'b0},
    '{ACT_STEP,  12'd0,    12'd0,    12'd0,    12'd0,    1'b0},
    '{ACT_START, 12'd10,   12'd10,   12'd17,   12'd10,   1'b0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid_i, in_stall_o, action_i;
  logic [CB-1:0] centre_x_i, centre_y_i, corner_x_i, corner_y_i;
  logic out_valid_o, out_stall_i;
  logic [1:0] kind_o;
  logic signed [OW-1:0] pos_x_o, pos_y_o, span_end_x_o;
  logic last_o, done_res_o;

  midpoint_ellipse_rasterizer_unit #(.COORD_BITS(CB)) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .centre_x_i  (centre_x_i),
    .centre_y_i  (centre_y_i),
    .corner_x_i  (corner_x_i),
    .corner_y_i  (corner_y_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .pos_x_o     (pos_x_o),
    .pos_y_o     (pos_y_o),
    .span_end_x_o(span_end_x_o),
    .last_o      (last_o),
    .done_res_o  (done_res_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic cfg_fill;
  logic [3:0] cfg_border;
  longint ctr_col, ctr_row, cur_x, cur_y, rx_sq, ry_sq, px_term, py_term, dec4;
  bit region_two, ellipse_active;
  beat_t pending_beats[$];

  bit no_idle = 1'b0;
  int hold_req = 0;
  int hold_ack = 0;
  int errors = 0;
  int n_items = 0;
  int n_beats = 0;
  int n_spans = 0;
  int n_markers = 0;
  int n_finished = 0;
  int stuck_cycles = 0;

  function automatic int draw_wait();
    if (no_idle || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 19);
  endfunction

  function automatic logic [CB-1:0] offset_coord(logic [CB-1:0] c, int d);
    if (int'(c) + d > COORD_MAX || (int'(c) >= d && $urandom_range(0, 1) == 1))
      return c - CB'(d);
    return c + CB'(d);
  endfunction

  task automatic push_beat(logic [1:0] k, longint px, longint py, longint ex, logic lst,
                           logic fin);
    beat_t b;
    b.kind = k;
    b.pos_x = OW'(px);
    b.pos_y = OW'(py);
    b.span_end = OW'(ex);
    b.last = lst;
    b.done = fin;
    pending_beats.push_back(b);
  endtask

  task automatic emit_position();
    longint s;
    logic fin;
    s = longint'(cfg_border);
    fin = (cur_y <= 0);
    if (fin) ellipse_active = 1'b0;
    if (cfg_fill) begin
      push_beat(KIND_SPAN, ctr_col - cur_x + s - 2, ctr_row + cur_y - s,
                ctr_col + cur_x - s + 2, 1'b0, fin);
      push_beat(KIND_SPAN, ctr_col - cur_x + s - 2, ctr_row - cur_y + s,
                ctr_col + cur_x - s + 2, 1'b0, fin);
    end
    push_beat(KIND_POINT, ctr_col + cur_x, ctr_row + cur_y, 0, 1'b0, fin);
    push_beat(KIND_POINT, ctr_col - cur_x, ctr_row + cur_y, 0, 1'b0, fin);
    push_beat(KIND_POINT, ctr_col + cur_x, ctr_row - cur_y, 0, 1'b0, fin);
    push_beat(KIND_POINT, ctr_col - cur_x, ctr_row - cur_y, 0, 1'b1, fin);
  endtask

  task automatic rasterize_item(logic act, logic [CB-1:0] cx, logic [CB-1:0] cy,
                                logic [CB-1:0] qx, logic [CB-1:0] qy);
    longint a, b, t, u;
    if (act == ACT_START) begin
      a = longint'(qx) - longint'(cx);
      b = longint'(qy) - longint'(cy);
      if (a < 0) a = -a;
      if (b < 0) b = -b;
      ctr_col = longint'(cx);
      ctr_row = longint'(cy);
      rx_sq = a * a;
      ry_sq = b * b;
      cur_x = 0;
      cur_y = b;
      px_term = 0;
      py_term = 2 * rx_sq * b;
      dec4 = 4 * ry_sq - 4 * rx_sq * b + rx_sq;
      region_two = 1'b0;
      ellipse_active = 1'b1;
      emit_position();
    end else if (!ellipse_active) begin
      push_beat(KIND_MARK, 0, 0, 0, 1'b1, 1'b1);
    end else begin
      if (!region_two && !(px_term < py_term)) begin
        t = 2 * cur_x + 1;
        u = cur_y - 1;
        region_two = 1'b1;
        dec4 = ry_sq * t * t + 4 * rx_sq * u * u - 4 * rx_sq * ry_sq;
      end
      if (!region_two) begin
        px_term += 2 * ry_sq;
        if (dec4 < 0) begin
          dec4 += 4 * (ry_sq + px_term);
        end else begin
          py_term -= 2 * rx_sq;
          dec4 += 4 * (ry_sq + px_term - py_term);
          cur_y--;
        end
        cur_x++;
      end else begin
        py_term -= 2 * rx_sq;
        if (dec4 > 0) begin
          dec4 += 4 * (rx_sq - py_term);
        end else begin
          px_term += 2 * ry_sq;
          dec4 += 4 * (rx_sq - py_term + px_term);
          cur_x++;
        end
        cur_y--;
      end
      emit_position();
    end
  endtask

  task automatic send_item(logic act, logic [CB-1:0] cx, logic [CB-1:0] cy,
                           logic [CB-1:0] qx, logic [CB-1:0] qy, logic typed);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    centre_x_i <= cx;
    centre_y_i <= cy;
    corner_x_i <= qx;
    corner_y_i <= qy;
    do @(posedge clk_i); while (in_stall_o);
    n_items++;
    if (typed) pending_beats.push_back(MARK_BEAT);
    else rasterize_item(act, cx, cy, qx, qy);
  endtask

  task automatic drain(int settle);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_beats.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == CFG_FILL_MODE) cfg_fill = val[0];
    else cfg_border = val[3:0];
  endtask

  task automatic run_ellipse(int max_rad, int step_cap);
    logic [CB-1:0] cx, cy, qx, qy;
    int steps;
    cx = CB'($urandom);
    cy = CB'($urandom);
    if (max_rad >= COORD_MAX) begin
      qx = CB'($urandom);
      qy = CB'($urandom);
    end else begin
      qx = offset_coord(cx, $urandom_range(0, max_rad));
      qy = offset_coord(cy, $urandom_range(0, max_rad));
    end
    send_item(ACT_START, cx, cy, qx, qy, 1'b0);
    steps = 0;
    while (ellipse_active && steps < step_cap) begin
      send_item(ACT_STEP, CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom), 1'b0);
      steps++;
    end
  endtask

  task automatic run_random(int count, bit do_hold, bit do_pause);
    int goal, choice;
    goal = n_items + count;
    while (n_items < goal) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if (n_items >= goal - count / 2) begin
        if (do_hold) hold_req++;
        if (do_pause) drain(0);
        do_hold = 0;
        do_pause = 0;
      end
      choice = $urandom_range(0, 9);
      if (choice < 6) run_ellipse($urandom_range(1, 8), 40);
      else if (choice == 6) run_ellipse(COORD_MAX, $urandom_range(1, 6));
      else if (choice == 7) run_ellipse($urandom_range(2, 12), $urandom_range(0, 3));
      else send_item(ACT_STEP, CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom),
                     1'b0);
    end
  endtask

  task automatic check_field(string name, logic [OW-1:0] exp_v, logic [OW-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, $signed(exp_v),
               $signed(act_v));
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat, kind %0d x %0d y %0d", $time, kind_o, pos_x_o,
                 pos_y_o);
        errors++;
      end else begin
        want = pending_beats.pop_front();
        check_field("kind", OW'(want.kind), OW'(kind_o));
        check_field("pos_x", want.pos_x, pos_x_o);
        check_field("pos_y", want.pos_y, pos_y_o);
        check_field("span_end_x", want.span_end, span_end_x_o);
        check_field("last", OW'(want.last), OW'(last_o));
        check_field("done_res", OW'(want.done), OW'(done_res_o));
        n_beats++;
        if (want.kind == KIND_SPAN) n_spans++;
        if (want.kind == KIND_MARK) n_markers++;
        if (want.kind == KIND_POINT && want.last && want.done) n_finished++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d beats outstanding", $time, IDLE_LIMIT,
               pending_beats.size());
      $display("midpoint_ellipse_rasterizer_unit regression: fail");
      $finish;
    end
  end

  initial begin : beat_sink
    int n;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_ack != hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_ack++;
      end else begin
        n = draw_wait();
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
        out_stall_i <= 1'b0;
        do @(posedge clk_i); while (!out_valid_o);
      end
    end
  end

  initial begin : stimulus
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    action_i = ACT_START;
    centre_x_i = '0;
    centre_y_i = '0;
    corner_x_i = '0;
    corner_y_i = '0;
    cfg_fill = 1'b0;
    cfg_border = BORDER_RESET;
    ctr_col = 0;
    ctr_row = 0;
    cur_x = 0;
    cur_y = 0;
    rx_sq = 0;
    ry_sq = 0;
    px_term = 0;
    py_term = 0;
    dec4 = 0;
    region_two = 1'b0;
    ellipse_active = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_ROWS; i++)
      send_item(DIRECTED[i].action, DIRECTED[i].cx, DIRECTED[i].cy, DIRECTED[i].qx,
                DIRECTED[i].qy, DIRECTED[i].typed);
    drain(SETTLE_CYCLES);

    write_reg(CFG_FILL_MODE, 32'd1);
    write_reg(CFG_BORDER_SIZE, 32'd15);
    run_random(PHASE_ITEMS, 0, 0);
    drain(SETTLE_CYCLES);

    // border of zero lies outside the legal range but must pass through unclamped
    write_reg(CFG_BORDER_SIZE, 32'd0);
    run_random(PHASE_ITEMS, 1, 0);
    drain(SETTLE_CYCLES);

    write_reg(CFG_FILL_MODE, 32'd0);
    write_reg(CFG_BORDER_SIZE, 32'd15);
    run_random(PHASE_ITEMS, 0, 1);
    drain(SETTLE_CYCLES);

    write_reg(CFG_FILL_MODE, 32'd1);
    write_reg(CFG_BORDER_SIZE, 32'd1);
    run_random(PHASE_ITEMS, 0, 0);
    drain(SETTLE_CYCLES);

    write_reg(CFG_FILL_MODE, 32'($urandom_range(0, 1)));
    write_reg(CFG_BORDER_SIZE, 32'($urandom_range(1, 15)));
    run_random(PHASE_ITEMS, 1, 0);
    drain(TAIL_CYCLES);

    $display("Covered %0d items over six register settings, %0d beats checked.", n_items,
             n_beats);
    $display("Beats held %0d fill spans and %0d idle markers; %0d ellipses ran to the end.",
             n_spans, n_markers, n_finished);
    if (errors == 0 && pending_beats.size() == 0) begin
      $display("midpoint_ellipse_rasterizer_unit regression: pass");
    end else begin
      $display("midpoint_ellipse_rasterizer_unit regression: fail");
    end
    $finish;
  end

endmodule
